>>> hdl/uts_pkg.sv
`default_nettype none

package uts_pkg;

  // matrix geometry and number format
  localparam int unsigned NUM_ROWS  = 16;
  localparam int unsigned NUM_COLS  = 16;
  localparam int unsigned ROW_W     = 4;
  localparam int unsigned COL_W     = 4;
  localparam int unsigned ADDR_W    = ROW_W + COL_W;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned SUM_W     = 36;
  localparam int unsigned ERR_W     = 40;
  localparam int unsigned LOG_STEPS = 16;

  localparam logic [WORD_W-1:0] WORD_ONES = '1;
  localparam logic [WORD_W-1:0] WORD_UNIT = WORD_W'(1) << FRAC_BITS;
  localparam logic [16:0]       EXP_ONE   = 17'd65536;

  // item codes
  typedef enum logic [2:0] {
    MODE_LOAD_ENTRY = 3'd0,
    MODE_LOAD_ROW   = 3'd1,
    MODE_LOAD_COL   = 3'd2,
    MODE_RUN        = 3'd3,
    MODE_READ       = 3'd4
  } mode_e;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_SAT   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_ROWS     = 3'd0;
  localparam logic [2:0] CFG_COLS     = 3'd1;
  localparam logic [2:0] CFG_EXPONENT = 3'd2;
  localparam logic [2:0] CFG_TOL      = 3'd3;
  localparam logic [2:0] CFG_MAX_ITER = 3'd4;

  // request to and response from the power unit
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] target;
    logic [SUM_W-1:0]  sum;
    logic [16:0]       expo;
  } pow_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] factor;
    logic              sat;
  } pow_rsp_t;

  typedef logic [LOG_STEPS-1:0][WORD_W-1:0] exp_tab_t;

  // integer square root, evaluated at elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] bitv;
    logic [63:0] rem;
    r    = '0;
    bitv = 64'd1 << 62;
    rem  = v;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + bitv) begin
        rem = rem - (r + bitv);
        r   = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // 2^(2^-(k+1)) in Q1.30
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] v;
    v = 64'd2 << 30;
    for (int k = 0; k < LOG_STEPS; k++) begin
      v      = isqrt64(v << 30);
      tab[k] = v[WORD_W-1:0];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

>>> hdl/uts_ram.sv
`default_nettype none

module uts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> hdl/uts_pow.sv
`default_nettype none

module uts_pow (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire uts_pkg::pow_req_t req_i,
  output uts_pkg::pow_rsp_t    rsp_o
);

  import uts_pkg::*;

  typedef enum logic [2:0] {
    P_IDLE,
    P_NORM,
    P_SQR,
    P_MULE,
    P_EXP,
    P_SHIFT
  } pstate_e;

  pstate_e             state_q;
  logic [SUM_W-1:0]    x_q;
  logic [SUM_W-1:0]    s_q;
  logic [5:0]          b_q;
  logic                pass_q;
  logic [3:0]          k_q;
  logic [30:0]         m_q;
  logic [15:0]         frac_q;
  logic signed [23:0]  logt_q;
  logic signed [24:0]  diff_q;
  logic signed [26:0]  p_q;
  logic [30:0]         mant_q;
  logic [16:0]         e_q;
  logic [WORD_W-1:0]   factor_q;
  logic                sat_q;
  logic                done_q;

  // shared multiplier
  logic signed [32:0]  mul_a;
  logic signed [32:0]  mul_b;
  logic signed [65:0]  prod;

  always_comb begin
    case (state_q)
      P_SQR: begin
        mul_a = {2'b00, m_q};
        mul_b = {2'b00, m_q};
      end
      P_MULE: begin
        mul_a = {{8{diff_q[24]}}, diff_q};
        mul_b = {16'd0, e_q};
      end
      P_EXP: begin
        mul_a = {2'b00, mant_q};
        mul_b = {1'b0, EXP_TAB[k_q]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // squaring step of the log
  logic [31:0]        sq;
  logic [30:0]        m_next;
  logic [15:0]        frac_next;
  logic [7:0]         b_off;
  logic signed [23:0] log_w;
  logic signed [24:0] diff_w;

  assign sq        = prod[61:30];
  assign m_next    = sq[31] ? sq[31:1] : sq[30:0];
  assign frac_next = {frac_q[14:0], sq[31]};
  assign b_off     = {2'b00, b_q} - 8'd16;
  assign log_w     = {b_off, frac_next};
  assign diff_w    = {logt_q[23], logt_q} - {log_w[23], log_w};

  // final scaling by the integer part
  logic signed [10:0] ip;
  logic signed [11:0] sh;
  logic signed [11:0] nsh;
  logic [63:0]        wide;
  logic [31:0]        shr;

  assign ip   = p_q[26:16];
  assign sh   = {ip[10], ip} - 12'sd14;
  assign nsh  = -sh;
  assign wide = {33'd0, mant_q} << sh[5:0];
  assign shr  = {1'b0, mant_q} >> nsh[4:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_IDLE;
      done_q  <= 1'b0;
      sat_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        P_IDLE: begin
          if (req_i.start) begin
            e_q <= req_i.expo;
            if (req_i.expo == '0) begin
              factor_q <= WORD_UNIT;
              sat_q    <= 1'b0;
              done_q   <= 1'b1;
            end else if (req_i.sum == '0) begin
              factor_q <= WORD_ONES;
              sat_q    <= 1'b1;
              done_q   <= 1'b1;
            end else if (req_i.target == '0) begin
              factor_q <= '0;
              sat_q    <= 1'b0;
              done_q   <= 1'b1;
            end else begin
              x_q     <= {4'd0, req_i.target};
              s_q     <= req_i.sum;
              b_q     <= 6'd35;
              pass_q  <= 1'b0;
              sat_q   <= 1'b0;
              state_q <= P_NORM;
            end
          end
        end
        // one bit of leading-one search per cycle
        P_NORM: begin
          if (x_q[SUM_W-1]) begin
            m_q     <= x_q[SUM_W-1:5];
            frac_q  <= '0;
            k_q     <= '0;
            state_q <= P_SQR;
          end else begin
            x_q <= x_q << 1;
            b_q <= b_q - 6'd1;
          end
        end
        P_SQR: begin
          m_q    <= m_next;
          frac_q <= frac_next;
          k_q    <= k_q + 4'd1;
          if (k_q == 4'd15) begin
            if (!pass_q) begin
              logt_q  <= log_w;
              x_q     <= s_q;
              b_q     <= 6'd35;
              pass_q  <= 1'b1;
              state_q <= P_NORM;
            end else begin
              diff_q  <= diff_w;
              state_q <= P_MULE;
            end
          end
        end
        P_MULE: begin
          p_q     <= prod[42:16];
          mant_q  <= 31'd1 << 30;
          k_q     <= '0;
          state_q <= P_EXP;
        end
        P_EXP: begin
          if (p_q[4'd15 - k_q]) begin
            mant_q <= prod[60:30];
          end
          k_q <= k_q + 4'd1;
          if (k_q == 4'd15) begin
            state_q <= P_SHIFT;
          end
        end
        P_SHIFT: begin
          if (!sh[11]) begin
            if (sh > 12'sd32 || wide[63:32] != '0) begin
              factor_q <= WORD_ONES;
              sat_q    <= 1'b1;
            end else begin
              factor_q <= wide[31:0];
            end
          end else if (nsh >= 12'sd31) begin
            factor_q <= '0;
          end else begin
            factor_q <= shr;
          end
          done_q  <= 1'b1;
          state_q <= P_IDLE;
        end
        default: state_q <= P_IDLE;
      endcase
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.factor = factor_q;
  assign rsp_o.sat    = sat_q;

endmodule

`default_nettype wire

>>> hdl/unbalanced_transport_scaling.sv
// Unbalanced matrix scaling on a 16x16 Q16.16 matrix held in a 256-word RAM.
// Load items (entry, row target, column target) and unused modes give their
// result in the cycle after they are accepted; a read item first waits in
// S_RDWAIT for the registered RAM read. A run item holds the input stalled
// until done: it forms the column sums, then per iteration computes one power
// factor per column and per row in the shared power unit (each with a
// bit-serial leading-one search per operand), rescales each entry twice with
// a 32x32 multiply and re-forms the column sums. The RAM's single read port
// and the bit-serial power unit bound the run time.
`default_nettype none

module unbalanced_transport_scaling (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  mode_i,
  input  wire logic [7:0]  index_i,
  input  wire logic [31:0] value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      read_value_o,
  output logic [15:0]      iterations_o,
  output logic             converged_o,
  output logic [1:0]       status_o
);

  import uts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDWAIT,
    S_SUM_RD,
    S_SUM_ACC,
    S_SUM_END,
    S_ITER,
    S_CF_START,
    S_CF_WAIT,
    S_A_RD,
    S_A_MUL,
    S_A_WR,
    S_RF_START,
    S_RF_WAIT,
    S_B_RD,
    S_B_MUL,
    S_B_WR
  } state_e;

  // configuration
  logic [4:0]  rows_q;
  logic [4:0]  cols_q;
  logic [16:0] expo_q;
  logic [31:0] tol_q;
  logic [15:0] max_iter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q     <= 5'd16;
      cols_q     <= 5'd16;
      expo_q     <= 17'd32768;
      tol_q      <= 32'd6554;
      max_iter_q <= 16'd1000;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROWS:     rows_q     <= cfg_wdata_i[4:0];
        CFG_COLS:     cols_q     <= cfg_wdata_i[4:0];
        CFG_EXPONENT: expo_q     <= cfg_wdata_i[16:0];
        CFG_TOL:      tol_q      <= cfg_wdata_i;
        CFG_MAX_ITER: max_iter_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // clamped run limits
  logic [ROW_W-1:0] row_last;
  logic [COL_W-1:0] col_last;
  logic [16:0]      expo_eff;
  logic [15:0]      cap;

  always_comb begin
    if (rows_q == '0) row_last = '0;
    else if (rows_q >= 5'(NUM_ROWS)) row_last = ROW_W'(NUM_ROWS - 1);
    else row_last = ROW_W'(rows_q - 5'd1);
    if (cols_q == '0) col_last = '0;
    else if (cols_q >= 5'(NUM_COLS)) col_last = COL_W'(NUM_COLS - 1);
    else col_last = COL_W'(cols_q - 5'd1);
    expo_eff = (expo_q > EXP_ONE) ? EXP_ONE : expo_q;
    cap      = (max_iter_q == '0) ? 16'd1 : max_iter_q;
  end

  state_e            state_q;
  logic [ROW_W-1:0]  r_q;
  logic [COL_W-1:0]  c_q;
  logic [SUM_W-1:0]  acc_q;
  logic [SUM_W-1:0]  rs_q;
  logic [ERR_W-1:0]  err_q;
  logic              first_q;
  logic              sat_q;
  logic [15:0]       iter_q;
  logic              conv_q;
  logic [WORD_W-1:0] f_q;
  logic [63:0]       prod_q;
  logic              out_valid_q;
  logic [31:0]       rd_q;
  logic [1:0]        status_q;

  logic [WORD_W-1:0] row_t_q   [NUM_ROWS];
  logic [WORD_W-1:0] col_t_q   [NUM_COLS];
  logic [SUM_W-1:0]  col_sum_q [NUM_COLS];
  logic [WORD_W-1:0] col_f_q   [NUM_COLS];

  logic accept;
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  // matrix RAM
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  uts_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NUM_ROWS * NUM_COLS)
  ) u_matrix (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // scaled entry with saturation
  logic [47:0]       scaled;
  logic              mul_sat;
  logic [WORD_W-1:0] mul_res;

  assign scaled  = prod_q[63:FRAC_BITS];
  assign mul_sat = scaled[47:32] != '0;
  assign mul_res = mul_sat ? WORD_ONES : scaled[31:0];

  always_comb begin
    ram_raddr = (state_q == S_IDLE) ? index_i : {r_q, c_q};
    ram_waddr = {r_q, c_q};
    ram_wdata = mul_res;
    ram_we    = 1'b0;
    if (state_q == S_A_WR || state_q == S_B_WR) begin
      ram_we = 1'b1;
    end else if (state_q == S_IDLE && accept && mode_e'(mode_i) == MODE_LOAD_ENTRY) begin
      ram_we    = 1'b1;
      ram_waddr = index_i;
      ram_wdata = value_i;
    end
  end

  // power unit
  pow_req_t pow_req;
  pow_rsp_t pow_rsp;

  always_comb begin
    pow_req.start  = (state_q == S_CF_START) || (state_q == S_RF_START);
    pow_req.expo   = expo_eff;
    pow_req.target = (state_q == S_RF_START) ? row_t_q[r_q] : col_t_q[c_q];
    pow_req.sum    = (state_q == S_RF_START) ? rs_q : col_sum_q[c_q];
  end

  uts_pow u_pow (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (pow_req),
    .rsp_o (pow_rsp)
  );

  // column sum change
  logic [SUM_W-1:0] sum_diff;
  logic [ERR_W-1:0] err_next;
  logic [SUM_W-1:0] sum_old;

  assign sum_old  = col_sum_q[c_q];
  assign sum_diff = (acc_q >= sum_old) ? acc_q - sum_old : sum_old - acc_q;
  assign err_next = err_q + ERR_W'(sum_diff);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      iter_q      <= '0;
      conv_q      <= 1'b0;
      sat_q       <= 1'b0;
      first_q     <= 1'b0;
      r_q         <= '0;
      c_q         <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            rd_q     <= '0;
            status_q <= STATUS_OK;
            case (mode_e'(mode_i))
              MODE_LOAD_ENTRY: out_valid_q <= 1'b1;
              MODE_LOAD_ROW: begin
                if (index_i < 8'(NUM_ROWS)) row_t_q[index_i[ROW_W-1:0]] <= value_i;
                else status_q <= STATUS_RANGE;
                out_valid_q <= 1'b1;
              end
              MODE_LOAD_COL: begin
                if (index_i < 8'(NUM_COLS)) col_t_q[index_i[COL_W-1:0]] <= value_i;
                else status_q <= STATUS_RANGE;
                out_valid_q <= 1'b1;
              end
              MODE_RUN: begin
                iter_q  <= '0;
                conv_q  <= 1'b0;
                sat_q   <= 1'b0;
                first_q <= 1'b1;
                r_q     <= '0;
                c_q     <= '0;
                acc_q   <= '0;
                err_q   <= '0;
                state_q <= S_SUM_RD;
              end
              MODE_READ: state_q <= S_RDWAIT;
              default: out_valid_q <= 1'b1;
            endcase
          end
        end
        S_RDWAIT: begin
          rd_q        <= ram_rdata;
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        // column sums: read an entry, then accumulate it
        S_SUM_RD: state_q <= S_SUM_ACC;
        S_SUM_ACC: begin
          acc_q <= acc_q + SUM_W'(ram_rdata);
          if (r_q == row_last) begin
            state_q <= S_SUM_END;
          end else begin
            r_q     <= r_q + 1'b1;
            state_q <= S_SUM_RD;
          end
        end
        S_SUM_END: begin
          col_sum_q[c_q] <= acc_q;
          acc_q          <= '0;
          r_q            <= '0;
          if (!first_q) err_q <= err_next;
          if (c_q == col_last) begin
            c_q <= '0;
            if (first_q) begin
              first_q <= 1'b0;
              state_q <= S_ITER;
            end else if (err_next < ERR_W'(tol_q)) begin
              conv_q      <= 1'b1;
              rd_q        <= '0;
              status_q    <= sat_q ? STATUS_SAT : STATUS_OK;
              out_valid_q <= 1'b1;
              state_q     <= S_IDLE;
            end else if (iter_q < cap) begin
              state_q <= S_ITER;
            end else begin
              rd_q        <= '0;
              status_q    <= sat_q ? STATUS_SAT : STATUS_OK;
              out_valid_q <= 1'b1;
              state_q     <= S_IDLE;
            end
          end else begin
            c_q     <= c_q + 1'b1;
            state_q <= S_SUM_RD;
          end
        end
        S_ITER: begin
          iter_q  <= iter_q + 16'd1;
          err_q   <= '0;
          c_q     <= '0;
          state_q <= S_CF_START;
        end
        // column factors
        S_CF_START: state_q <= S_CF_WAIT;
        S_CF_WAIT: begin
          if (pow_rsp.done) begin
            col_f_q[c_q] <= pow_rsp.factor;
            if (pow_rsp.sat) sat_q <= 1'b1;
            if (c_q == col_last) begin
              c_q     <= '0;
              r_q     <= '0;
              rs_q    <= '0;
              state_q <= S_A_RD;
            end else begin
              c_q     <= c_q + 1'b1;
              state_q <= S_CF_START;
            end
          end
        end
        // column scaling of one row
        S_A_RD: state_q <= S_A_MUL;
        S_A_MUL: begin
          prod_q  <= ram_rdata * col_f_q[c_q];
          state_q <= S_A_WR;
        end
        S_A_WR: begin
          rs_q <= rs_q + SUM_W'(mul_res);
          if (mul_sat) sat_q <= 1'b1;
          if (c_q == col_last) begin
            c_q     <= '0;
            state_q <= S_RF_START;
          end else begin
            c_q     <= c_q + 1'b1;
            state_q <= S_A_RD;
          end
        end
        // row factor
        S_RF_START: state_q <= S_RF_WAIT;
        S_RF_WAIT: begin
          if (pow_rsp.done) begin
            f_q <= pow_rsp.factor;
            if (pow_rsp.sat) sat_q <= 1'b1;
            c_q     <= '0;
            state_q <= S_B_RD;
          end
        end
        // row scaling
        S_B_RD: state_q <= S_B_MUL;
        S_B_MUL: begin
          prod_q  <= ram_rdata * f_q;
          state_q <= S_B_WR;
        end
        S_B_WR: begin
          if (mul_sat) sat_q <= 1'b1;
          if (c_q == col_last) begin
            c_q <= '0;
            if (r_q == row_last) begin
              r_q     <= '0;
              acc_q   <= '0;
              state_q <= S_SUM_RD;
            end else begin
              r_q     <= r_q + 1'b1;
              rs_q    <= '0;
              state_q <= S_A_RD;
            end
          end else begin
            c_q     <= c_q + 1'b1;
            state_q <= S_B_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = rd_q;
  assign iterations_o = iter_q;
  assign converged_o  = conv_q;
  assign status_o     = status_q;

endmodule

`default_nettype wire

>>> dv/tb_unbalanced_transport_scaling.sv
`timescale 1ns / 100ps

module tb_unbalanced_transport_scaling;
  import uts_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 10000000;
  localparam int unsigned NUM_PHASES  = 14;
  localparam int unsigned PHASE_ITEMS = 117;
  localparam int unsigned QUIET_ITEMS = 40;
  localparam logic [2:0]  MODE_SPARE5 = 3'd5;
  localparam logic [2:0]  MODE_SPARE7 = 3'd7;

  typedef struct {
    logic [31:0] read_value;
    logic [15:0] iterations;
    logic        converged;
    logic [1:0]  status;
  } result_t;

  // scaling predictor plus queue of expected results
  class scaling_scoreboard;
    bit [31:0]   mat[256];
    bit [31:0]   row_tgt[16];
    bit [31:0]   col_tgt[16];
    bit [63:0]   col_sum[16];
    bit [63:0]   prev_sum[16];
    bit [63:0]   exp2_tab[16];
    bit [15:0]   iter_cnt;
    bit          run_conv;
    bit          sat_seen;
    bit [4:0]    rows_cfg;
    bit [4:0]    cols_cfg;
    bit [16:0]   expo_cfg;
    bit [31:0]   tol_cfg;
    bit [15:0]   cap_cfg;
    result_t     pending[$];
    int unsigned mismatches;

    function new();
      bit [63:0] v;
      bit [63:0] root;
      bit [63:0] rem;
      v = 64'd2 << 30;
      for (int k = 0; k < 16; k++) begin
        // bitwise square root of v << 30
        rem  = v << 30;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
          if ((root | (64'd1 << b)) * (root | (64'd1 << b)) <= rem) root |= 64'd1 << b;
        end
        v           = root;
        exp2_tab[k] = v;
      end
      rows_cfg = 16; cols_cfg = 16; expo_cfg = 32768; tol_cfg = 6554; cap_cfg = 1000;
      iter_cnt = 0; run_conv = 0; mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        CFG_ROWS:     rows_cfg = data[4:0];
        CFG_COLS:     cols_cfg = data[4:0];
        CFG_EXPONENT: expo_cfg = data[16:0];
        CFG_TOL:      tol_cfg  = data;
        CFG_MAX_ITER: cap_cfg  = data[15:0];
        default: ;
      endcase
    endfunction

    // log2 in signed Q.16, input in Q16.16
    function longint log2_fix(bit [63:0] x);
      int        b;
      bit [63:0] m;
      bit [63:0] frac;
      b = 63;
      frac = 0;
      while (b > 0 && !x[b]) b--;
      m = (b >= 30) ? (x >> (b - 30)) : (x << (30 - b));
      for (int k = 0; k < 16; k++) begin
        m    = (m * m) >> 30;
        frac = frac << 1;
        if (m >= (64'd1 << 31)) begin
          frac |= 1;
          m = m >> 1;
        end
      end
      return (longint'(b) - 16) * 65536 + longint'(frac);
    endfunction

    function bit [31:0] power_of(bit [63:0] t, bit [63:0] s);
      bit [16:0] e;
      longint    p;
      longint    ip;
      bit [15:0] fp;
      bit [63:0] mant;
      longint    sh;
      e = (expo_cfg > EXP_ONE) ? EXP_ONE : expo_cfg;
      if (e == 0) return WORD_UNIT;
      if (s == 0) begin
        sat_seen = 1;
        return WORD_ONES;
      end
      if (t == 0) return 0;
      p    = ((log2_fix(t) - log2_fix(s)) * longint'(e)) >>> 16;
      ip   = p >>> 16;
      fp   = 16'(p - ip * 65536);
      mant = 64'd1 << 30;
      for (int k = 0; k < 16; k++) begin
        if (fp[15-k]) mant = (mant * exp2_tab[k]) >> 30;
      end
      sh = ip + 16 - 30;
      if (sh >= 0) begin
        if (sh > 32) begin
          sat_seen = 1;
          return WORD_ONES;
        end
        mant = mant << sh;
      end else begin
        mant = (-sh >= 63) ? 64'd0 : (mant >> (-sh));
      end
      if (mant > 64'hFFFF_FFFF) begin
        sat_seen = 1;
        return WORD_ONES;
      end
      return mant[31:0];
    endfunction

    function bit [31:0] scale(bit [31:0] a, bit [31:0] f);
      bit [63:0] p;
      p = (64'(a) * 64'(f)) >> 16;
      if (p > 64'hFFFF_FFFF) begin
        sat_seen = 1;
        return WORD_ONES;
      end
      return p[31:0];
    endfunction

    function void sum_columns(int nr, int nc);
      for (int c = 0; c < nc; c++) begin
        col_sum[c] = 0;
        for (int r = 0; r < nr; r++) col_sum[c] += mat[r*16+c];
      end
    endfunction

    function void run_scaling();
      int        nr;
      int        nc;
      int        cap;
      bit [63:0] err;
      bit [63:0] rsum;
      bit [31:0] f;
      bit [31:0] cfac[16];
      nr = (rows_cfg < 1) ? 1 : ((rows_cfg > 16) ? 16 : rows_cfg);
      nc = (cols_cfg < 1) ? 1 : ((cols_cfg > 16) ? 16 : cols_cfg);
      cap = (cap_cfg == 0) ? 1 : cap_cfg;
      sat_seen = 0;
      sum_columns(nr, nc);
      iter_cnt = 0;
      run_conv = 0;
      do begin
        err = 0;
        iter_cnt++;
        prev_sum = col_sum;
        for (int c = 0; c < nc; c++) cfac[c] = power_of(col_tgt[c], col_sum[c]);
        for (int r = 0; r < nr; r++) begin
          rsum = 0;
          for (int c = 0; c < nc; c++) begin
            mat[r*16+c] = scale(mat[r*16+c], cfac[c]);
            rsum += mat[r*16+c];
          end
          f = power_of(row_tgt[r], rsum);
          for (int c = 0; c < nc; c++) mat[r*16+c] = scale(mat[r*16+c], f);
        end
        sum_columns(nr, nc);
        for (int c = 0; c < nc; c++)
          err += (col_sum[c] >= prev_sum[c]) ? col_sum[c] - prev_sum[c]
                                             : prev_sum[c] - col_sum[c];
        if (err < tol_cfg) begin
          run_conv = 1;
          break;
        end
      end while (iter_cnt < cap);
    endfunction

    // note an accepted input transfer and queue its result
    function void note_input(logic [2:0] mode, logic [7:0] idx, logic [31:0] val);
      result_t res;
      res.read_value = 0;
      res.status     = STATUS_OK;
      case (mode)
        MODE_LOAD_ENTRY: mat[idx] = val;
        MODE_LOAD_ROW:   if (idx < 16) row_tgt[idx] = val; else res.status = STATUS_RANGE;
        MODE_LOAD_COL:   if (idx < 16) col_tgt[idx] = val; else res.status = STATUS_RANGE;
        MODE_RUN: begin
          run_scaling();
          if (sat_seen) res.status = STATUS_SAT;
        end
        MODE_READ:       res.read_value = mat[idx];
        default: ;
      endcase
      res.iterations = iter_cnt;
      res.converged  = run_conv;
      pending.push_back(res);
    endfunction

    // compare an output transfer against the oldest expectation
    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: read_value=%h", got.read_value);
        return;
      end
      want = pending.pop_front();
      if (got.read_value !== want.read_value || got.iterations !== want.iterations ||
          got.converged !== want.converged || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp rd=%h it=%0d cv=%0d st=%0d, got rd=%h it=%0d cv=%0d st=%0d",
                   want.read_value, want.iterations, want.converged, want.status,
                   got.read_value, got.iterations, got.converged, got.status);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_index_i = CFG_ROWS;
  logic [31:0] cfg_wdata_i = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [2:0]  mode_i = MODE_LOAD_ENTRY;
  logic [7:0]  index_i = 0;
  logic [31:0] value_i = 0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [31:0] read_value_o;
  logic [15:0] iterations_o;
  logic        converged_o;
  logic [1:0]  status_o;

  scaling_scoreboard sb;
  bit                quiet = 0;
  int unsigned       cycles = 0;

  unbalanced_transport_scaling DUT (.*);

  always #5 clk_i = ~clk_i;

  // run-time guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stall bursts, check each transfer
  initial begin
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        out_stall_i <= 0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.read_value = read_value_o;
      got.iterations = iterations_o;
      got.converged  = converged_o;
      got.status     = status_o;
      sb.check_result(got);
    end
  end

  // one input transfer, with an optional idle burst first
  task automatic send(logic [2:0] mode, logic [7:0] idx, logic [31:0] val);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1;
    mode_i     <= mode;
    index_i    <= idx;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(mode, idx, val);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // register writes, only with the block idle
  task automatic write_regs(logic [31:0] rows, logic [31:0] cols, logic [31:0] expo,
                            logic [31:0] tol, logic [31:0] cap);
    logic [31:0] data[5];
    data = '{rows, cols, expo, tol, cap};
    drain();
    for (int i = 0; i < 5; i++) begin
      cfg_we_i    <= 1;
      cfg_index_i <= 3'(i);
      cfg_wdata_i <= data[i];
      @(posedge clk_i);
      sb.write_reg(3'(i), data[i]);
    end
    cfg_we_i <= 0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return WORD_ONES;
      2, 3:    return $urandom;
      default: return $urandom_range(1, 32'h0010_0000);
    endcase
  endfunction

  task automatic random_item();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      send(MODE_LOAD_ENTRY, 8'($urandom), pick_value());
    else if (pick < 50) send(MODE_LOAD_ROW, ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                              : 8'($urandom_range(0, 15)),
                             pick_value());
    else if (pick < 60) send(MODE_LOAD_COL, ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                              : 8'($urandom_range(0, 15)),
                             pick_value());
    else if (pick < 64) send(MODE_RUN, 8'($urandom), $urandom);
    else if (pick < 96) send(MODE_READ, 8'($urandom), $urandom);
    else                send(3'($urandom_range(MODE_SPARE5, MODE_SPARE7)), 8'($urandom),
                             $urandom);
  endtask

  initial begin
    logic [31:0] rows;
    logic [31:0] cols;
    logic [31:0] expo;
    logic [31:0] tol;
    logic [31:0] cap;
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // fill every entry and target so nothing unwritten is ever read
    for (int i = 0; i < 256; i++) send(MODE_LOAD_ENTRY, 8'(i), $urandom_range(1, 32'h0004_0000));
    for (int i = 0; i < 16; i++) send(MODE_LOAD_ROW, 8'(i), $urandom_range(1, 32'h0040_0000));
    for (int i = 0; i < 16; i++) send(MODE_LOAD_COL, 8'(i), $urandom_range(1, 32'h0040_0000));

    // directed: extremes, every mode, out of range, unused modes
    write_regs(16, 16, 65536, 0, 1);
    send(MODE_READ, 8'd255, 0);
    send(MODE_LOAD_ROW, 8'd16, WORD_ONES);
    send(MODE_LOAD_COL, 8'd255, WORD_ONES);
    send(MODE_SPARE5, 8'd0, WORD_ONES);
    send(MODE_SPARE7, 8'd255, 0);
    send(MODE_RUN, 8'd0, 0);
    send(MODE_LOAD_ENTRY, 8'd0, WORD_ONES);
    send(MODE_LOAD_ENTRY, 8'd255, 0);
    send(MODE_READ, 8'd0, 0);
    send(MODE_READ, 8'd255, 0);
    // zero column, zero target, huge entry
    for (int r = 0; r < 4; r++) send(MODE_LOAD_ENTRY, 8'(r*16 + 3), 0);
    send(MODE_LOAD_COL, 8'd1, 0);
    send(MODE_LOAD_ROW, 8'd0, WORD_ONES);
    write_regs(0, 4, 131071, 32'hFFFF_FFFF, 0);
    send(MODE_RUN, 8'd0, 0);
    send(MODE_READ, 8'd1, 0);
    // exponent zero: factors of one, converges at once
    write_regs(31, 31, 0, 1, 65535);
    send(MODE_RUN, 8'd0, 0);
    send(MODE_READ, 8'd17, 0);
    write_regs(3, 5, 32768, 0, 3);
    send(MODE_RUN, 8'd0, 0);

    // random phases over several register settings
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case ($urandom_range(0, 4))
        0:       rows = 1;
        1:       rows = 16;
        2:       rows = $urandom;
        default: rows = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 4))
        0:       cols = 1;
        1:       cols = 16;
        2:       cols = $urandom;
        default: cols = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 5))
        0:       expo = 0;
        1:       expo = 65536;
        2:       expo = $urandom;
        default: expo = $urandom_range(0, 65536);
      endcase
      case ($urandom_range(0, 3))
        0:       tol = 0;
        1:       tol = WORD_ONES;
        2:       tol = 6554;
        default: tol = $urandom;
      endcase
      // a long cap only where convergence is certain on the first pass
      if (expo[16:0] == 0 && tol != 0) cap = 65535;
      else                             cap = $urandom_range(0, 3);
      write_regs(rows, cols, expo, tol, cap);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == NUM_PHASES - 1 && i >= PHASE_ITEMS - QUIET_ITEMS) quiet = 1;
        random_item();
      end
    end

    in_valid_i <= 0;
    quiet = 1;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
